FILE: design/pfla_pkg.sv
// Package for the page free list allocator.
// Holds page geometry, status and mode codes, and the sequencer state type.
// No dependencies.
package pfla_pkg;

    localparam int PAGE_PIECES   = 64;
    localparam int HEADER_PIECES = 8;
    localparam int PIECE_W       = 6;
    localparam int LEN_W         = 7;
    localparam int STEP_W        = 7;
    localparam int SUM_W         = 8;
    localparam int RAM_W         = PIECE_W + LEN_W;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOSPACE = 3'd1,
        ST_NOTFREE = 3'd2,
        ST_NOTUSED = 3'd3,
        ST_BAD     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_FIND  = 2'd1,
        MODE_ALLOC = 2'd2,
        MODE_FREE  = 2'd3
    } t_mode;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_CLR,
        S_FIND_RD,
        S_FIND_EV,
        S_AL_RD,
        S_AL_EV,
        S_AL_SPLIT,
        S_AL_FIN,
        S_AL_LINK,
        S_AL_ENT,
        S_FR_N,
        S_FR_RD,
        S_FR_EV,
        S_FR_SUC,
        S_FR_LINK
    } t_state;

endpackage

FILE: design/pfla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfla_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/page_free_list_allocator.sv
// Top level of the page free list allocator: sequencer, list head, in-use bits.
// Depends on pfla_pkg and pfla_ram.
//
// Manages the 64 pieces of one directory page; pieces 0..7 are the header.
// A word is taken when start is high and busy is low; exactly one result word
// follows, shown for one cycle with o_strobe high, and busy drops in that same
// cycle. The receiver cannot stall, so sample on o_strobe. Link and length of
// every free area live in one RAM with a single read port and registered read
// data, so each list step issues the address and then evaluates the data, and
// the length of the walk sets how long a request takes; a walk passes at most
// 64 free areas. Bad requests and not-in-use frees answer in the cycle after
// the word.
// After reset, busy stays high for one cycle while the first free area is
// written.
module page_free_list_allocator
    import pfla_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic [PIECE_W-1:0] i_piece,
    input  logic [LEN_W-1:0]   i_pieces,
    output logic               o_strobe,
    output logic [2:0]         o_status,
    output logic [PIECE_W-1:0] o_area_index,
    output logic [LEN_W-1:0]   o_area_length
);

    localparam logic [PIECE_W-1:0] HDR  = PIECE_W'(HEADER_PIECES);
    localparam logic [LEN_W-1:0]   SPAN = LEN_W'(PAGE_PIECES - HEADER_PIECES);

    t_state                  r_state, n_state;
    logic [PIECE_W-1:0]      r_ent, n_ent;
    logic [LEN_W-1:0]        r_want, n_want;
    logic [PIECE_W-1:0]      r_head, n_head;
    logic [PIECE_W-1:0]      r_cur, n_cur;
    logic [PIECE_W-1:0]      r_prev, n_prev;
    logic [LEN_W-1:0]        r_prev_len, n_prev_len;
    logic [PIECE_W-1:0]      r_lnk, n_lnk;
    logic [LEN_W-1:0]        r_len_e, n_len_e;
    logic [LEN_W-1:0]        r_n, n_n;
    logic [STEP_W-1:0]       r_steps, n_steps;
    logic [PAGE_PIECES-1:0]  r_in_use, n_in_use;
    logic                    r_strobe, n_strobe;
    t_status                 r_status, n_status;
    logic [PIECE_W-1:0]      r_idx, n_idx;
    logic [LEN_W-1:0]        r_len, n_len;

    logic                    ram_we;
    logic [PIECE_W-1:0]      ram_waddr;
    logic [RAM_W-1:0]        ram_wdata;
    logic [PIECE_W-1:0]      ram_raddr;
    logic [RAM_W-1:0]        ram_rdata;
    logic [PIECE_W-1:0]      rd_link;
    logic [LEN_W-1:0]        rd_len;

    logic [SUM_W-1:0]        cur_end;
    logic [LEN_W-1:0]        have;
    logic [SUM_W-1:0]        frag_sum;
    logic                    jp, js;
    logic [PIECE_W-1:0]      slnk;
    logic [LEN_W-1:0]        slen;

    // Each RAM word: {next link, area length}.
    pfla_ram #(
        .WIDTH(RAM_W),
        .DEPTH(PAGE_PIECES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign rd_link = ram_rdata[RAM_W-1:LEN_W];
    assign rd_len  = ram_rdata[LEN_W-1:0];

    // Shared arithmetic on the area just read and the latched request.
    assign cur_end  = {2'b00, r_cur} + {1'b0, rd_len};
    assign have     = rd_len - {1'b0, r_ent - r_cur};
    assign frag_sum = {2'b00, r_ent} + {1'b0, r_want};
    assign jp       = (r_prev != '0) &&
                      (({2'b00, r_prev} + {1'b0, r_prev_len}) == {2'b00, r_ent});
    assign js       = (r_cur != '0) &&
                      (({2'b00, r_ent} + {1'b0, r_n}) == {2'b00, r_cur});
    assign slnk     = js ? rd_link : r_cur;
    assign slen     = js ? rd_len : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_head   <= HDR;
            r_in_use <= '0;
            r_strobe <= 1'b0;
            r_steps  <= '0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_in_use <= n_in_use;
            r_strobe <= n_strobe;
            r_steps  <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent      <= n_ent;
        r_want     <= n_want;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_prev_len <= n_prev_len;
        r_lnk      <= n_lnk;
        r_len_e    <= n_len_e;
        r_n        <= n_n;
        r_status   <= n_status;
        r_idx      <= n_idx;
        r_len      <= n_len;
    end

    always_comb begin
        n_state    = r_state;
        n_ent      = r_ent;
        n_want     = r_want;
        n_head     = r_head;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_prev_len = r_prev_len;
        n_lnk      = r_lnk;
        n_len_e    = r_len_e;
        n_n        = r_n;
        n_steps    = r_steps;
        n_in_use   = r_in_use;
        n_strobe   = 1'b0;
        n_status   = r_status;
        n_idx      = r_idx;
        n_len      = r_len;
        ram_we     = 1'b0;
        ram_waddr  = r_ent;
        ram_wdata  = '0;
        ram_raddr  = r_cur;

        unique case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = HDR;
                ram_wdata = {PIECE_W'(0), SPAN};
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                ram_raddr = i_piece;
                if (start) begin
                    n_ent   = i_piece;
                    n_want  = i_pieces;
                    n_cur   = r_head;
                    n_prev  = '0;
                    n_steps = '0;
                    n_idx   = '0;
                    n_len   = '0;
                    unique case (t_mode'(i_mode))
                        MODE_CLEAR: n_state = S_CLR;
                        MODE_FIND: begin
                            if (i_pieces == '0) begin
                                n_strobe = 1'b1;
                                n_status = ST_BAD;
                            end else begin
                                n_state = S_FIND_RD;
                            end
                        end
                        MODE_ALLOC: begin
                            if (i_pieces == '0 || i_piece < HDR) begin
                                n_strobe = 1'b1;
                                n_status = ST_BAD;
                            end else begin
                                n_state = S_AL_RD;
                            end
                        end
                        MODE_FREE: begin
                            if (i_piece < HDR) begin
                                n_strobe = 1'b1;
                                n_status = ST_BAD;
                            end else if (!r_in_use[i_piece]) begin
                                n_strobe = 1'b1;
                                n_status = ST_NOTUSED;
                            end else begin
                                // read of the entry's length is issued now
                                n_in_use[i_piece] = 1'b0;
                                n_state           = S_FR_N;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = HDR;
                ram_wdata = {PIECE_W'(0), SPAN};
                n_head    = HDR;
                n_in_use  = '0;
                n_strobe  = 1'b1;
                n_status  = ST_OK;
                n_idx     = HDR;
                n_len     = SPAN;
                n_state   = S_IDLE;
            end
            S_FIND_RD: begin
                if (r_cur == '0 || r_steps[STEP_W-1]) begin
                    n_strobe = 1'b1;
                    n_status = ST_NOSPACE;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_FIND_EV;
                end
            end
            S_FIND_EV: begin
                if (rd_len >= r_want) begin
                    n_strobe = 1'b1;
                    n_status = ST_OK;
                    n_idx    = r_cur;
                    n_len    = rd_len;
                    n_state  = S_IDLE;
                end else begin
                    n_cur   = rd_link;
                    n_steps = r_steps + 1'b1;
                    n_state = S_FIND_RD;
                end
            end
            S_AL_RD: begin
                if (r_cur == '0 || r_cur > r_ent || r_steps[STEP_W-1]) begin
                    n_strobe = 1'b1;
                    n_status = ST_NOTFREE;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_AL_EV;
                end
            end
            S_AL_EV: begin
                priority if (r_cur == r_ent) begin
                    if (rd_len < r_want) begin
                        n_strobe = 1'b1;
                        n_status = ST_NOTFREE;
                        n_state  = S_IDLE;
                    end else begin
                        n_lnk   = rd_link;
                        n_len_e = rd_len;
                        n_state = S_AL_FIN;
                    end
                end else if ({2'b00, r_ent} < cur_end) begin
                    if (have < r_want) begin
                        n_strobe = 1'b1;
                        n_status = ST_NOTFREE;
                        n_state  = S_IDLE;
                    end else begin
                        // split: tail of the area becomes its own area at the entry
                        ram_we     = 1'b1;
                        ram_waddr  = r_ent;
                        ram_wdata  = {rd_link, have};
                        n_lnk      = rd_link;
                        n_len_e    = have;
                        n_prev     = r_cur;
                        n_prev_len = {1'b0, r_ent - r_cur};
                        n_state    = S_AL_SPLIT;
                    end
                end else begin
                    n_prev     = r_cur;
                    n_prev_len = rd_len;
                    n_cur      = rd_link;
                    n_steps    = r_steps + 1'b1;
                    n_state    = S_AL_RD;
                end
            end
            S_AL_SPLIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_prev;
                ram_wdata = {r_ent, r_prev_len};
                n_state   = S_AL_FIN;
            end
            S_AL_FIN: begin
                if (r_len_e == r_want) begin
                    // exact fit: unlink the area
                    if (r_prev == '0) begin
                        n_head = r_lnk;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_prev;
                        ram_wdata = {r_lnk, r_prev_len};
                    end
                    n_in_use[r_ent] = 1'b1;
                    n_strobe        = 1'b1;
                    n_status        = ST_OK;
                    n_idx           = r_ent;
                    n_len           = r_want;
                    n_state         = S_IDLE;
                end else if (frag_sum >= SUM_W'(PAGE_PIECES)) begin
                    n_strobe = 1'b1;
                    n_status = ST_NOTFREE;
                    n_state  = S_IDLE;
                end else begin
                    // trailing fragment stays free
                    ram_we                      = 1'b1;
                    ram_waddr                   = frag_sum[PIECE_W-1:0];
                    ram_wdata                   = {r_lnk, r_len_e - r_want};
                    n_in_use[frag_sum[PIECE_W-1:0]] = 1'b0;
                    n_cur                       = frag_sum[PIECE_W-1:0];
                    n_state                     = S_AL_LINK;
                end
            end
            S_AL_LINK: begin
                if (r_prev == '0) begin
                    n_head = r_cur;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_prev;
                    ram_wdata = {r_cur, r_prev_len};
                end
                n_state = S_AL_ENT;
            end
            S_AL_ENT: begin
                ram_we          = 1'b1;
                ram_waddr       = r_ent;
                ram_wdata       = {r_lnk, r_want};
                n_in_use[r_ent] = 1'b1;
                n_strobe        = 1'b1;
                n_status        = ST_OK;
                n_idx           = r_ent;
                n_len           = r_want;
                n_state         = S_IDLE;
            end
            S_FR_N: begin
                n_n     = rd_len;
                n_state = S_FR_RD;
            end
            S_FR_RD: begin
                // read the current link either way: it is the successor at loop end
                if (r_cur != '0 && r_cur < r_ent && !r_steps[STEP_W-1]) begin
                    n_state = S_FR_EV;
                end else begin
                    n_state = S_FR_SUC;
                end
            end
            S_FR_EV: begin
                n_prev     = r_cur;
                n_prev_len = rd_len;
                n_cur      = rd_link;
                n_steps    = r_steps + 1'b1;
                n_state    = S_FR_RD;
            end
            S_FR_SUC: begin
                if (jp) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_prev;
                    ram_wdata = {slnk, r_prev_len + r_n + slen};
                    n_strobe  = 1'b1;
                    n_status  = ST_OK;
                    n_idx     = r_prev;
                    n_len     = r_prev_len + r_n + slen;
                    n_state   = S_IDLE;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_ent;
                    ram_wdata = {slnk, r_n + slen};
                    n_len_e   = r_n + slen;
                    n_state   = S_FR_LINK;
                end
            end
            S_FR_LINK: begin
                if (r_prev == '0) begin
                    n_head = r_ent;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_prev;
                    ram_wdata = {r_ent, r_prev_len};
                end
                n_strobe = 1'b1;
                n_status = ST_OK;
                n_idx    = r_ent;
                n_len    = r_len_e;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_area_index  = r_idx;
    assign o_area_length = r_len;

`ifndef ASSERT_OFF
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while sequencer busy");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> (o_area_index == '0 && o_area_length == '0))
        else $error("failed request returned a nonzero area");

    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_OK) |-> (o_area_length != '0 && o_area_index >= HDR))
        else $error("successful request returned an empty or header area");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= STEP_W'(PAGE_PIECES))
        else $error("list walk exceeded page size");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Testbench for page_free_list_allocator: directed and random words, with
// a scoreboard holding its own copy of the free list. Depends on pfla_pkg.
module tb;
    import pfla_pkg::*;

    localparam int LIMIT = 2_000_000;

    typedef struct packed {
        t_status            st;
        logic [PIECE_W-1:0] idx;
        logic [LEN_W-1:0]   len;
    } t_answer;

    // Scoreboard: mirror of the page's free list plus queue of answers due.
    class page_scoreboard;
        int      head;
        int      nxt [PAGE_PIECES];
        int      alen [PAGE_PIECES];
        bit      used [PAGE_PIECES];
        t_answer due[$];
        int      errors;

        function new();
            for (int i = 0; i < PAGE_PIECES; i++) begin
                nxt[i] = 0;
                alen[i] = 0;
            end
            errors = 0;
            rebuild();
        endfunction

        function void rebuild();
            for (int i = 0; i < PAGE_PIECES; i++) used[i] = 0;
            head = HEADER_PIECES;
            nxt[HEADER_PIECES] = 0;
            alen[HEADER_PIECES] = PAGE_PIECES - HEADER_PIECES;
        endfunction

        function bit link_ok(int p);
            return p != 0 && p < PAGE_PIECES;
        endfunction

        function void relink(int prev, int val);
            if (prev == 0) head = val;
            else nxt[prev] = val;
        endfunction

        function t_status find_fit(int want, output int idx, output int len);
            int cur;
            int steps;
            cur = head;
            steps = 0;
            if (want == 0) return ST_BAD;
            while (link_ok(cur) && steps < PAGE_PIECES) begin
                if (alen[cur] >= want) begin
                    idx = cur;
                    len = alen[cur];
                    return ST_OK;
                end
                cur = nxt[cur];
                steps++;
            end
            return ST_NOSPACE;
        endfunction

        function t_status carve(int ent, int want, output int idx, output int len);
            int cur, prev, steps, have, frag;
            bit found;
            cur = head;
            prev = 0;
            steps = 0;
            found = 0;
            if (want == 0 || ent < HEADER_PIECES || ent >= PAGE_PIECES) return ST_BAD;
            while (link_ok(cur) && cur <= ent && steps < PAGE_PIECES) begin
                if (cur == ent) begin
                    if (alen[cur] < want) return ST_NOTFREE;
                    found = 1;
                    break;
                end
                if (ent < cur + alen[cur]) begin
                    // split the area in front of the entry
                    have = alen[cur] - (ent - cur);
                    if (have < want) return ST_NOTFREE;
                    nxt[ent] = nxt[cur];
                    alen[ent] = have;
                    nxt[cur] = ent;
                    alen[cur] = ent - cur;
                    prev = cur;
                    found = 1;
                    break;
                end
                prev = cur;
                cur = nxt[cur];
                steps++;
            end
            if (!found) return ST_NOTFREE;
            if (alen[ent] == want) begin
                relink(prev, nxt[ent]);
            end else begin
                frag = ent + want;
                if (frag >= PAGE_PIECES) return ST_NOTFREE;
                nxt[frag] = nxt[ent];
                alen[frag] = alen[ent] - want;
                used[frag] = 0;
                relink(prev, frag);
                alen[ent] = want;
            end
            used[ent] = 1;
            idx = ent;
            len = want;
            return ST_OK;
        endfunction

        function t_status release_entry(int ent, output int idx, output int len);
            int n, prev, succ, steps, merged;
            bit jp, js;
            prev = 0;
            succ = head;
            steps = 0;
            if (ent < HEADER_PIECES || ent >= PAGE_PIECES) return ST_BAD;
            if (!used[ent]) return ST_NOTUSED;
            n = alen[ent];
            used[ent] = 0;
            while (link_ok(succ) && succ < ent && steps < PAGE_PIECES) begin
                prev = succ;
                succ = nxt[succ];
                steps++;
            end
            if (!link_ok(succ)) succ = 0;
            jp = prev != 0 && prev + alen[prev] == ent;
            js = succ != 0 && ent + n == succ;
            if (jp) begin
                if (js) nxt[prev] = nxt[succ];
                merged = prev;
                alen[prev] = alen[prev] + n;
            end else begin
                nxt[ent] = js ? nxt[succ] : succ;
                relink(prev, ent);
                merged = ent;
            end
            if (js) alen[merged] = alen[merged] + alen[succ];
            idx = merged;
            len = alen[merged];
            return ST_OK;
        endfunction

        // Note an accepted word and queue the answer it must produce.
        function void note_word(t_mode m, int p, int w);
            t_answer a;
            int idx, len;
            t_status st;
            idx = 0;
            len = 0;
            case (m)
                MODE_CLEAR: begin
                    rebuild();
                    idx = HEADER_PIECES;
                    len = PAGE_PIECES - HEADER_PIECES;
                    st = ST_OK;
                end
                MODE_FIND:  st = find_fit(w, idx, len);
                MODE_ALLOC: st = carve(p, w, idx, len);
                default:    st = release_entry(p, idx, len);
            endcase
            if (st != ST_OK) begin
                idx = 0;
                len = 0;
            end
            a.st = st;
            a.idx = idx[PIECE_W-1:0];
            a.len = len[LEN_W-1:0];
            due.push_back(a);
        endfunction

        // Compare one result word against the oldest answer due.
        function void check_word(t_answer got);
            t_answer want;
            if (due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result st=%0d idx=%0d len=%0d",
                             $time, got.st, got.idx, got.len);
                return;
            end
            want = due.pop_front();
            if (got.st !== want.st || got.idx !== want.idx || got.len !== want.len) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch exp st=%0d idx=%0d len=%0d got st=%0d idx=%0d len=%0d",
                             $time, want.st, want.idx, want.len, got.st, got.idx, got.len);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_mode;
    logic [PIECE_W-1:0] i_piece;
    logic [LEN_W-1:0]   i_pieces;
    logic               o_strobe;
    logic [2:0]         o_status;
    logic [PIECE_W-1:0] o_area_index;
    logic [LEN_W-1:0]   o_area_length;

    page_scoreboard sb;
    int             cycles = 0;

    page_free_list_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_piece       (i_piece),
        .i_pieces      (i_pieces),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_area_index  (o_area_index),
        .o_area_length (o_area_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung block ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Results can't be stalled: take every strobed word at the edge ending it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_word('{t_status'(o_status), o_area_index, o_area_length});
    end

    // Present one word and hold it until the block takes it. Called right
    // after a rising edge; leaves start high so back-to-back words are legal.
    task automatic send_word(t_mode m, int p, int w);
        start    <= 1'b1;
        i_mode   <= m;
        i_piece  <= p[PIECE_W-1:0];
        i_pieces <= w[LEN_W-1:0];
        do @(posedge i_clk); while (busy);
        sb.note_word(m, p, w);
    endtask

    // Drop start for a few cycles with the given odds in percent.
    task automatic maybe_idle(int pct);
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Pick a mostly well-formed word from the mirrored list: carve inside
    // real free areas, free entries really in use, with some noise mixed in.
    task automatic pick_word(output t_mode m, output int p, output int w);
        int areas[$];
        int owned[$];
        int cur, steps, r, a, room;
        cur = sb.head;
        steps = 0;
        while (sb.link_ok(cur) && steps < PAGE_PIECES) begin
            areas.push_back(cur);
            cur = sb.nxt[cur];
            steps++;
        end
        for (int i = HEADER_PIECES; i < PAGE_PIECES; i++)
            if (sb.used[i]) owned.push_back(i);
        r = $urandom_range(99);
        m = MODE_FIND;
        p = $urandom_range(63);
        w = $urandom_range(1, 20);
        if (r < 4) begin
            m = MODE_CLEAR;
        end else if (r < 20) begin
            if ($urandom_range(3) == 0) w = $urandom_range(1, 64);
        end else if (r < 60) begin
            m = MODE_ALLOC;
            if (areas.size() > 0) begin
                a = areas[$urandom_range(areas.size() - 1)];
                p = ($urandom_range(1) == 0) ? a : a + $urandom_range(sb.alen[a] - 1);
                room = sb.alen[a] - (p - a);
                w = $urandom_range(1, room < 8 ? room : 8);
                if ($urandom_range(9) == 0) w = room;
                if ($urandom_range(9) == 0) w = room + $urandom_range(1, 3);
            end
        end else if (r < 95) begin
            m = MODE_FREE;
            if (owned.size() > 0 && $urandom_range(9) != 0)
                p = owned[$urandom_range(owned.size() - 1)];
        end else begin
            m = t_mode'($urandom_range(3));
            w = $urandom_range(127);
        end
    endtask

    initial begin
        t_mode m;
        int    p, w, pct;
        sb       = new();
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_mode   = MODE_CLEAR;
        i_piece  = '0;
        i_pieces = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, every mode and each corner case.
        send_word(MODE_FIND,  0, 0);    // zero pieces wanted
        send_word(MODE_FIND,  0, 56);   // whole page fits
        send_word(MODE_FIND,  63, 57);  // too big
        send_word(MODE_FIND,  0, 127);
        send_word(MODE_ALLOC, 0, 4);    // inside header
        send_word(MODE_ALLOC, 7, 4);
        send_word(MODE_ALLOC, 8, 0);    // zero pieces wanted
        send_word(MODE_ALLOC, 8, 57);   // area too short at its start
        send_word(MODE_ALLOC, 8, 4);
        send_word(MODE_ALLOC, 20, 5);   // split area ahead of entry
        send_word(MODE_ALLOC, 63, 1);   // exact fit at page end
        send_word(MODE_ALLOC, 14, 1);   // index inside a free area: split ahead of it
        send_word(MODE_FREE,  5, 0);    // inside header
        send_word(MODE_FREE,  30, 0);   // never allocated
        send_word(MODE_ALLOC, 12, 2);
        send_word(MODE_FREE,  20, 0);
        send_word(MODE_FREE,  8, 0);    // no free neighbor to merge with
        send_word(MODE_FREE,  12, 0);   // merge with preceding area
        send_word(MODE_FREE,  63, 0);
        send_word(MODE_ALLOC, 9, 64);
        send_word(MODE_ALLOC, 40, 3);
        send_word(MODE_CLEAR, 0, 0);
        send_word(MODE_FREE,  40, 0);   // stale entry after clear
        send_word(MODE_ALLOC, 8, 56);   // whole page
        send_word(MODE_FIND,  0, 1);    // nothing left
        send_word(MODE_CLEAR, 63, 127);

        // Random: sender gaps 17%, then 53%, then none.
        for (int n = 0; n < 750; n++) begin
            pct = (n < 250) ? 17 : (n < 500) ? 53 : 0;
            pick_word(m, p, w);
            send_word(m, p, w);
            maybe_idle(pct);
        end
        start <= 1'b0;

        // Drain, then give the walk time to show any stray word.
        while (sb.due.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
